@@ hw/rtl/nus_pkg.sv @@
// Shared types and constants for the NAL unit splitter.
`default_nettype none
package nus_pkg;

  localparam int PosW      = 32;
  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);
  localparam int FifoCw    = $clog2(FifoDepth + 1);

  localparam logic [7:0] ByteZero = 8'h00;
  localparam logic [7:0] ByteOne  = 8'h01;
  localparam logic [7:0] MaskAvc  = 8'h1f;
  localparam logic [7:0] MaskHevc = 8'h7f;

  localparam logic ModeAvc  = 1'b0;
  localparam logic ModeHevc = 1'b1;

  typedef struct packed {
    logic [31:0] unit_offset;
    logic [31:0] unit_length;
    logic [5:0]  unit_type;
    logic        final_unit;
    logic        run_last;
  } res_t;

  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

  typedef struct packed {
    logic unit_pending;
    logic awaiting_type;
    logic pos_zero;
  } stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/nus_in_if.sv @@
// Input byte channel.
`default_nettype none
interface nus_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, data_byte, end_of_stream, input ready);
  modport sink   (input valid, data_byte, end_of_stream, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/nus_out_if.sv @@
// Result channel.
`default_nettype none
interface nus_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] unit_offset;
  logic [31:0] unit_length;
  logic [5:0]  unit_type;
  logic        final_unit;
  logic        run_last;

  modport source (output valid, unit_offset, unit_length, unit_type, final_unit, run_last,
                  input ready);
  modport sink   (input valid, unit_offset, unit_length, unit_type, final_unit, run_last,
                  output ready);
endinterface
`default_nettype wire

@@ hw/rtl/nus_cfg_if.sv @@
// Configuration write channel.
`default_nettype none
interface nus_cfg_if;
  logic valid;
  logic ready;
  logic codec_mode;

  modport source (output valid, codec_mode, input ready);
  modport sink   (input valid, codec_mode, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/nus_scan.sv @@
// Start code scanner: per-byte state update and unit result generation.
`default_nettype none
module nus_scan (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    data_byte,
  input  wire logic          end_of_stream,
  input  wire logic          cfg_we,
  input  wire logic          cfg_mode,
  output nus_pkg::push_t     push,
  output nus_pkg::stat_t     stat
);
  import nus_pkg::*;

  logic            codec_mode_r;
  logic [PosW-1:0] byte_pos_r, byte_pos_nxt;
  logic [1:0]      zero_run_r, zero_run_nxt;
  logic            pending_r, pending_nxt;
  logic [PosW-1:0] pend_off_r, pend_off_nxt;
  logic [5:0]      pend_type_r, pend_type_nxt;
  logic            awaiting_r, awaiting_nxt;

  logic [5:0]      cur_type;
  logic [7:0]      hevc_bits;
  logic [7:0]      avc_bits;
  logic            is_start;
  logic [PosW-1:0] start_pos;
  logic [PosW-1:0] len0;
  logic [PosW-1:0] len1;
  logic            open_pend;
  logic [PosW-1:0] open_off;
  logic [5:0]      open_type;
  logic            v0, v1;

  always_comb begin
    hevc_bits = data_byte & MaskHevc;
    avc_bits  = data_byte & MaskAvc;
    if (awaiting_r) begin
      cur_type = (codec_mode_r == ModeHevc) ? hevc_bits[6:1] : avc_bits[5:0];
    end else begin
      cur_type = pend_type_r;
    end

    is_start  = (data_byte == ByteOne) && (zero_run_r >= 2'd2);
    start_pos = byte_pos_r - ((zero_run_r == 2'd3) ? PosW'(3) : PosW'(2));
    len0      = start_pos - pend_off_r;

    if (data_byte == ByteZero) begin
      zero_run_nxt = (zero_run_r == 2'd3) ? zero_run_r : zero_run_r + 2'd1;
    end else begin
      zero_run_nxt = 2'd0;
    end

    if (is_start) begin
      open_pend = 1'b1;
      open_off  = start_pos;
      open_type = 6'd0;
    end else begin
      open_pend = pending_r;
      open_off  = pend_off_r;
      open_type = cur_type;
    end
    len1 = byte_pos_r + PosW'(1) - open_off;

    v0 = is_start && pending_r;
    v1 = end_of_stream && open_pend;

    push.v0             = v0;
    push.v1             = v1;
    push.r0.unit_offset = 32'(pend_off_r);
    push.r0.unit_length = 32'(len0);
    push.r0.unit_type   = cur_type;
    push.r0.final_unit  = 1'b0;
    push.r0.run_last    = !v1;
    push.r1.unit_offset = 32'(open_off);
    push.r1.unit_length = 32'(len1);
    push.r1.unit_type   = open_type;
    push.r1.final_unit  = 1'b1;
    push.r1.run_last    = 1'b1;

    if (end_of_stream) begin
      byte_pos_nxt  = '0;
      zero_run_nxt  = 2'd0;
      pending_nxt   = 1'b0;
      pend_off_nxt  = '0;
      pend_type_nxt = 6'd0;
      awaiting_nxt  = 1'b0;
    end else begin
      byte_pos_nxt  = byte_pos_r + PosW'(1);
      pending_nxt   = open_pend;
      pend_off_nxt  = open_off;
      pend_type_nxt = open_type;
      awaiting_nxt  = is_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_mode_r <= ModeAvc;
      byte_pos_r   <= '0;
      zero_run_r   <= 2'd0;
      pending_r    <= 1'b0;
      pend_off_r   <= '0;
      pend_type_r  <= 6'd0;
      awaiting_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        codec_mode_r <= cfg_mode;
      end
      if (accept) begin
        byte_pos_r  <= byte_pos_nxt;
        zero_run_r  <= zero_run_nxt;
        pending_r   <= pending_nxt;
        pend_off_r  <= pend_off_nxt;
        pend_type_r <= pend_type_nxt;
        awaiting_r  <= awaiting_nxt;
      end
    end
  end

  assign stat.unit_pending  = pending_r;
  assign stat.awaiting_type = awaiting_r;
  assign stat.pos_zero      = (byte_pos_r == '0);

endmodule
`default_nettype wire

@@ hw/rtl/nus_res_fifo.sv @@
// Result queue: takes up to two results per cycle, delivers one.
`default_nettype none
module nus_res_fifo (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire nus_pkg::push_t           push,
  input  wire logic                     push_en,
  input  wire logic                     pop,
  output nus_pkg::res_t                 head,
  output logic [nus_pkg::FifoCw-1:0]    count
);
  import nus_pkg::*;

  res_t              mem [FifoDepth];
  logic [FifoAw-1:0] wp_r, wp_nxt;
  logic [FifoAw-1:0] rp_r, rp_nxt;
  logic [FifoCw-1:0] cnt_r, cnt_nxt;
  logic [FifoCw-1:0] n_push;
  logic              do_pop;
  res_t              first;

  always_comb begin
    n_push = '0;
    if (push_en) begin
      n_push = FifoCw'(push.v0) + FifoCw'(push.v1);
    end
    first   = push.v0 ? push.r0 : push.r1;
    do_pop  = pop && (cnt_r != '0);
    wp_nxt  = wp_r + n_push[FifoAw-1:0];
    rp_nxt  = do_pop ? rp_r + FifoAw'(1) : rp_r;
    cnt_nxt = cnt_r + n_push - FifoCw'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (n_push != '0) begin
      mem[wp_r] <= first;
    end
    if (n_push == FifoCw'(2)) begin
      mem[wp_r + FifoAw'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign head  = mem[rp_r];
  assign count = cnt_r;

endmodule
`default_nettype wire

@@ hw/rtl/nal_unit_splitter_unit.sv @@
// Top level of the NAL unit splitter: scanner plus result queue.
// A result is written into the result queue when the byte that closes it is accepted.
// Throughput: one byte per cycle; a byte that closes two units pushes both into the
// single-read result queue (four entries, needs room for two to accept).
// Reset (rst_n low, synchronous): scan state, codec_mode and queue cleared.
`default_nettype none
module nal_unit_splitter_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  nus_in_if.sink    in_ch,
  nus_out_if.source out_ch,
  nus_cfg_if.sink   cfg_ch
);
  import nus_pkg::*;

  push_t             push;
  stat_t             stat;
  res_t              head;
  logic [FifoCw-1:0] count;
  logic              in_acc;
  logic              out_acc;

  assign in_ch.ready  = (count <= FifoCw'(FifoDepth - 2));
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_acc      = out_ch.valid && out_ch.ready;

  nus_scan u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_acc),
    .data_byte     (in_ch.data_byte),
    .end_of_stream (in_ch.end_of_stream),
    .cfg_we        (cfg_ch.valid),
    .cfg_mode      (cfg_ch.codec_mode),
    .push          (push),
    .stat          (stat)
  );

  nus_res_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_en (in_acc),
    .pop     (out_ch.ready),
    .head    (head),
    .count   (count)
  );

  assign out_ch.valid       = (count != '0);
  assign out_ch.unit_offset = head.unit_offset;
  assign out_ch.unit_length = head.unit_length;
  assign out_ch.unit_type   = head.unit_type;
  assign out_ch.final_unit  = head.final_unit;
  assign out_ch.run_last    = head.run_last;

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= FifoCw'(FifoDepth))
    else $error("result queue overfilled");

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.end_of_stream |=>
      !stat.unit_pending && !stat.awaiting_type && stat.pos_zero)
    else $error("scan state not cleared after end of stream");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !in_acc |=> count == $past(count) - FifoCw'(1))
    else $error("queue count wrong after pop");

  a_type_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    stat.awaiting_type |-> stat.unit_pending)
    else $error("awaiting type byte with no open unit");

endmodule
`default_nettype wire

@@ dv/nus_unit_tracker.sv @@
// Watches the splitter's channels, predicts each unit from the accepted bytes and checks results.
module nus_unit_tracker (
  input  logic clk,
  input  logic rst_n,
  nus_in_if    in_ch,
  nus_out_if   out_ch,
  nus_cfg_if   cfg_ch,
  output int   mismatches,
  output int   outstanding,
  output int   units_checked,
  output int   bytes_seen
);
  import nus_pkg::*;

  logic        mode_q;
  logic [31:0] position;
  logic [1:0]  zeros;
  logic        open_unit;
  logic [31:0] open_offset;
  logic [5:0]  open_type;
  logic        type_next;
  res_t        units_due[$];
  res_t        got;
  res_t        want;

  // scan state after end of stream or reset; mode is kept
  task automatic clear_scan();
    position    = '0;
    zeros       = '0;
    open_unit   = 1'b0;
    open_offset = '0;
    open_type   = '0;
    type_next   = 1'b0;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic eos);
    logic [7:0]  field;
    logic [31:0] start;
    res_t        made[2];
    int          n;
    n = 0;
    if (type_next) begin
      field     = (mode_q == ModeHevc) ? ((b & MaskHevc) >> 1) : (b & MaskAvc);
      open_type = field[5:0];
      type_next = 1'b0;
    end
    if (b == ByteZero) begin
      if (zeros != 2'd3) zeros = zeros + 2'd1;
    end else begin
      if (b == ByteOne && zeros >= 2'd2) begin
        start = position - ((zeros == 2'd3) ? 32'd3 : 32'd2);
        if (open_unit) begin
          made[n] = '{unit_offset: open_offset, unit_length: start - open_offset,
                      unit_type: open_type, final_unit: 1'b0, run_last: 1'b0};
          n++;
        end
        open_unit   = 1'b1;
        open_offset = start;
        open_type   = '0;
        type_next   = 1'b1;
      end
      zeros = '0;
    end
    if (eos) begin
      if (open_unit) begin
        made[n] = '{unit_offset: open_offset, unit_length: position + 32'd1 - open_offset,
                    unit_type: open_type, final_unit: 1'b1, run_last: 1'b0};
        n++;
      end
      clear_scan();
    end else begin
      position = position + 32'd1;
    end
    if (n > 0) made[n - 1].run_last = 1'b1;
    for (int i = 0; i < n; i++) units_due = {units_due, made[i]};
  endtask

  task automatic flag_unit(input string what, input res_t exp_r, input res_t act_r);
    mismatches++;
    if (mismatches <= 10)
      $display({"%s unit: expected off=%0d len=%0d type=%0d fin=%b last=%b, ",
                "got off=%0d len=%0d type=%0d fin=%b last=%b"},
               what, exp_r.unit_offset, exp_r.unit_length, exp_r.unit_type, exp_r.final_unit,
               exp_r.run_last, act_r.unit_offset, act_r.unit_length, act_r.unit_type,
               act_r.final_unit, act_r.run_last);
  endtask

  initial begin
    mismatches    = 0;
    outstanding   = 0;
    units_checked = 0;
    bytes_seen    = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q = ModeAvc;
      clear_scan();
      units_due.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) mode_q = cfg_ch.codec_mode;
      if (in_ch.valid && in_ch.ready) begin
        bytes_seen++;
        scan_byte(in_ch.data_byte, in_ch.end_of_stream);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{unit_offset: out_ch.unit_offset, unit_length: out_ch.unit_length,
                unit_type: out_ch.unit_type, final_unit: out_ch.final_unit,
                run_last: out_ch.run_last};
        if (units_due.size() == 0) begin
          flag_unit("unexpected", '0, got);
        end else begin
          want = units_due.pop_front();
          units_checked++;
          if (got !== want) flag_unit("wrong", want, got);
        end
      end
    end
    outstanding = units_due.size();
  end

endmodule

@@ dv/nal_unit_splitter_unit_test.sv @@
// Stimulus and verdict for the NAL unit splitter: byte streams, mode writes, random stalls.
module nal_unit_splitter_unit_test;
  import nus_pkg::*;

  localparam int RandomBytes = 1650;

  logic clk;
  logic rst_n;
  logic in_quiet;
  logic out_quiet;
  int   fail_count;
  int   outstanding;
  int   units_checked;
  int   bytes_seen;
  int   bytes_sent;
  int   streams_sent;
  int   mode_writes;

  nus_in_if  in_ch ();
  nus_out_if out_ch ();
  nus_cfg_if cfg_ch ();

  nal_unit_splitter_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  nus_unit_tracker unit_watch (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .mismatches    (fail_count),
    .outstanding   (outstanding),
    .units_checked (units_checked),
    .bytes_seen    (bytes_seen)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #5000000;
    $display("nal_unit_splitter_unit: mismatch");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.end_of_stream <= eos;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_seq(input logic [7:0] seq[$], input logic stop);
    foreach (seq[i]) send_byte(seq[i], stop && (i == seq.size() - 1));
    streams_sent++;
  endtask

  // no request in flight, every unit returned
  task automatic hold_until_empty();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.codec_mode <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    mode_writes++;
  endtask

  function automatic logic [7:0] stream_byte();
    int r;
    r = $urandom_range(0, 15);
    if (r < 3) return ByteZero;
    if (r == 3) return ByteOne;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_stream();
    logic [7:0] s[$];
    int         kind;
    int         units;
    int         nz;
    int         r;
    logic       stop;
    logic       cut;
    kind = $urandom_range(0, 9);
    stop = ($urandom_range(0, 9) != 0);
    cut  = 1'b0;
    if (kind == 0) begin
      repeat ($urandom_range(1, 24)) s = {s, stream_byte()};
    end else if (kind == 1) begin
      repeat ($urandom_range(1, 2)) s = {s, 8'($urandom_range(0, 2))};
    end else begin
      repeat ($urandom_range(0, 3)) s = {s, stream_byte()};
      units = $urandom_range(1, 4);
      while (units > 0 && !cut) begin
        r  = $urandom_range(0, 15);
        nz = (r == 0) ? 1 : (r < 3) ? $urandom_range(4, 5) : $urandom_range(2, 3);
        repeat (nz) s = {s, ByteZero};
        s = {s, ByteOne};
        units--;
        if (units == 0 && $urandom_range(0, 7) == 0) begin
          cut = 1'b1;
        end else begin
          s = {s, 8'($urandom_range(0, 255))};
          repeat ($urandom_range(0, 12)) s = {s, stream_byte()};
        end
      end
    end
    send_seq(s, stop);
  endtask

  initial begin
    int stall;
    out_ch.ready = 1'b0;
    out_quiet    = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 63) == 0) out_quiet = ~out_quiet;
      stall = out_quiet ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.end_of_stream = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.codec_mode   = ModeAvc;
    rst_n               = 1'b0;
    in_quiet            = 1'b0;
    bytes_sent          = 0;
    streams_sent        = 0;
    mode_writes         = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // two units closed by one byte, four-byte code, stream ending on a start code
    write_mode(ModeAvc);
    send_seq('{8'h00, 8'h00, 8'h01, 8'h65, 8'hff, 8'h00, 8'h00, 8'h00, 8'h01, 8'he1,
               8'h00, 8'h00, 8'h01}, 1'b1);
    // too short for any unit
    send_seq('{8'h00, 8'h01}, 1'b1);
    hold_until_empty();
    // saturated zero run, widest type field, stream ending on the type byte
    write_mode(ModeHevc);
    send_seq('{8'h00, 8'h00, 8'h01, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h40}, 1'b1);
    hold_until_empty();

    while (bytes_sent < RandomBytes + 25) begin
      in_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 11) == 0) begin
        hold_until_empty();
        if ($urandom_range(0, 1) == 1) write_mode(1'($urandom_range(0, 1)));
      end
      send_stream();
    end
    hold_until_empty();
    repeat (12) @(negedge clk);

    $display("sent %0d bytes (%0d accepted) in %0d streams with %0d mode writes",
             bytes_sent, bytes_seen, streams_sent, mode_writes);
    $display("%0d units checked", units_checked);
    if (fail_count == 0 && outstanding == 0) begin
      $display("nal_unit_splitter_unit: match");
    end else begin
      $display("nal_unit_splitter_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/nus_pkg.sv
hw/rtl/nus_in_if.sv
hw/rtl/nus_out_if.sv
hw/rtl/nus_cfg_if.sv
hw/rtl/nus_scan.sv
hw/rtl/nus_res_fifo.sv
hw/rtl/nal_unit_splitter_unit.sv
dv/nus_unit_tracker.sv
dv/nal_unit_splitter_unit_test.sv
